[src/mbrtu_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus RTU poll package
// Shared constants and the CRC-16/Modbus byte update function.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;

  localparam logic [2:0] RegSlaveAddress = 3'd0;
  localparam logic [2:0] RegBaseRegister = 3'd1;
  localparam logic [2:0] RegGroupSize    = 3'd2;
  localparam logic [2:0] RegGroupCount   = 3'd3;
  localparam logic [2:0] RegLastGroup    = 3'd4;

  localparam logic OpPoll = 1'b0;
  localparam logic OpRx   = 1'b1;

  // One byte of CRC-16/Modbus: eight shift steps on a 16-bit value.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

[src/modbus_rtu_poll_and_reply_check.sv]
// ----------------------------------------------------------------------------
// Modbus RTU poll and reply check
// Builds read-holding-registers requests and scans received bursts for a reply.
// ----------------------------------------------------------------------------
// Sequence: a poll first reduces the group index by repeated subtraction when a lowered
// group count leaves it out of range, then forms the request and runs its CRC, then
// gives one byte per cycle when not stalled (eight bytes). A byte that does not end
// a burst is taken directly in idle. A burst end scans: per candidate, each byte read
// (up to the data byte count plus five) passes a wait state and a step state.
// Reset clears fill count, group index, control and registers; not the buffer.
module modbus_rtu_poll_and_reply_check #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  input  logic        rx_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        frame_end,
  output logic        reply_ok,
  output logic [5:0]  reply_offset,
  output logic [6:0]  reply_length,
  output logic [7:0]  group_tag,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mbrtu_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);
  // Wide enough for offset + 255 + 5.
  localparam int PW = FW + 2 > 10 ? FW + 2 : 10;

  typedef enum logic [3:0] {
    S_IDLE, S_POLL_MUL, S_POLL_CRC, S_POLL_OUT,
    S_SCAN_START, S_SCAN_WAIT, S_SCAN_STEP, S_VERDICT
  } state_t;

  state_t state;
  logic [7:0]  slave_address;
  logic [15:0] base_register;
  logic [6:0]  group_size;
  logic [7:0]  group_count;
  logic [6:0]  last_group_size;

  logic [FW-1:0] rx_fill;
  logic [7:0]    current_group;

  // Request build registers.
  logic [7:0]  gi;
  logic [14:0] prod;
  logic [7:0]  req [8];
  logic [2:0]  bidx;
  logic [15:0] crc;

  // Scan registers.
  logic [FW-1:0] cand;
  logic [PW-1:0] pos;
  logic [7:0]    dlen;
  logic          found;

  // Buffer RAM.
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [7:0] gc;
  assign gc = (group_count == 8'd0) ? 8'd1 : group_count;

  assign ram_we = (state == S_IDLE) && in_valid && opcode == OpRx &&
                  (rx_fill < FW'(BUFFER_BYTES));

  mbrtu_ram #(.Width(8), .Depth(BUFFER_BYTES)) u_buf (
    .clk(clk), .we(ram_we), .waddr(rx_fill[AW-1:0]), .wdata(rx_byte),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Address of the next scan read.
  always_comb begin
    ram_raddr = AW'(cand + pos[FW-1:0]);
  end

  assign in_stall = (state != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      base_register <= 16'd4096;
      group_size <= 7'd12;
      group_count <= 8'd4;
      last_group_size <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSlaveAddress: slave_address <= cfg_data[7:0];
        RegBaseRegister: base_register <= cfg_data;
        RegGroupSize:    group_size <= cfg_data[6:0];
        RegGroupCount:   group_count <= cfg_data[7:0];
        RegLastGroup:    last_group_size <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rx_fill <= '0;
      current_group <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == OpPoll) begin
              gi <= current_group;
              state <= S_POLL_MUL;
            end else begin
              if (rx_fill < FW'(BUFFER_BYTES)) rx_fill <= rx_fill + FW'(1);
              if (rx_last) begin
                cand <= '0;
                found <= 1'b0;
                state <= S_SCAN_START;
              end
            end
          end
        end
        // Reduce the index by repeated subtraction, then multiply.
        S_POLL_MUL: begin
          logic [7:0] gmod;
          gmod = (gi >= gc) ? gi - gc : gi;
          if (gmod >= gc) begin
            gi <= gmod;
          end else begin
            current_group <= gmod;
            gi <= gmod;
            prod <= 15'(gmod * group_size);
            bidx <= '0;
            crc <= CrcInit;
            state <= S_POLL_CRC;
          end
        end
        // Form the bytes and run the CRC one byte a cycle.
        S_POLL_CRC: begin
          logic [6:0] cnt;
          cnt = (last_group_size != 7'd0 && gi >= gc - 8'd1) ? last_group_size
                                                              : group_size;
          if (bidx == 3'd0) begin
            req[0] <= slave_address;
            req[1] <= FuncReadHolding;
            {req[2], req[3]} <= base_register + 16'(prod);
            req[4] <= 8'd0;
            req[5] <= {1'b0, cnt};
          end
          if (bidx != 3'd0) crc <= crc_byte(crc, req[bidx - 3'd1]);
          if (bidx == 3'd6) begin
            bidx <= '0;
            state <= S_POLL_OUT;
          end else begin
            bidx <= bidx + 3'd1;
          end
        end
        S_POLL_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            kind <= 1'b0;
            tx_byte <= (bidx == 3'd6) ? crc[7:0] :
                       (bidx == 3'd7) ? crc[15:8] : req[bidx];
            frame_end <= (bidx == 3'd7);
            reply_ok <= 1'b0;
            reply_offset <= '0;
            reply_length <= '0;
            group_tag <= '0;
            if (bidx == 3'd7) state <= S_IDLE;
            bidx <= bidx + 3'd1;
          end
        end
        // New candidate: need three bytes ahead.
        S_SCAN_START: begin
          if (out_valid && out_stall) begin
            state <= S_SCAN_START;
          end else begin
            out_valid <= 1'b0;
            if (PW'(cand) + PW'(2) < PW'(rx_fill)) begin
              pos <= '0;
              crc <= CrcInit;
              dlen <= '0;
              state <= S_SCAN_WAIT;
            end else begin
              state <= S_VERDICT;
            end
          end
        end
        S_SCAN_WAIT: begin
          state <= S_SCAN_STEP;
        end
        // Byte at cand+pos is in ram_rdata.
        S_SCAN_STEP: begin
          logic rej;
          logic adv;
          rej = 1'b0;
          adv = 1'b1;
          if (pos == PW'(0) && ram_rdata != slave_address) rej = 1'b1;
          if (pos == PW'(1) && ram_rdata != FuncReadHolding) rej = 1'b1;
          if (pos == PW'(2)) begin
            dlen <= ram_rdata;
            if (PW'(cand) + PW'(ram_rdata) + PW'(5) > PW'(rx_fill)) rej = 1'b1;
          end
          if (pos > PW'(2) && pos == PW'(dlen) + PW'(3) && ram_rdata != crc[7:0])
            rej = 1'b1;
          if (pos == PW'(dlen) + PW'(4) && pos > PW'(3)) begin
            adv = 1'b0;
            if (ram_rdata == crc[15:8]) begin
              found <= 1'b1;
              state <= S_VERDICT;
            end else begin
              cand <= cand + FW'(1);
              state <= S_SCAN_START;
            end
          end
          if (rej) begin
            cand <= cand + FW'(1);
            state <= S_SCAN_START;
          end else if (adv) begin
            if (pos <= PW'(2) || pos < PW'(dlen) + PW'(3)) crc <= crc_byte(crc, ram_rdata);
            pos <= pos + PW'(1);
            state <= S_SCAN_WAIT;
          end
        end
        S_VERDICT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            kind <= 1'b1;
            tx_byte <= '0;
            frame_end <= 1'b1;
            reply_ok <= found;
            reply_offset <= found ? 6'(cand) : 6'd0;
            reply_length <= found ? 7'(dlen + 8'd3) : 7'd0;
            group_tag <= found ? current_group : 8'd0;
            if (found)
              current_group <= (current_group + 8'd1 >= gc) ? 8'd0 : current_group + 8'd1;
            rx_fill <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_POLL_OUT && state != S_VERDICT && state != S_SCAN_START
          && out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Fill count never exceeds the buffer.
  a_fill: assert property (@(posedge clk) disable iff (rst) rx_fill <= FW'(BUFFER_BYTES))
    else $error("fill overflow");
  // A stalled result keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({kind, tx_byte, frame_end, reply_ok,
      reply_offset, reply_length, group_tag})) else $error("result changed under stall");
  // Input is only taken while idle.
  a_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == S_IDLE) else $error("stall");
endmodule

[src/mbrtu_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mbrtu_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
